// File: hw/rtl/hdc_pkg.sv
// Shared types, constants and color ramp tables of the heightmap decimator.
package hdc_pkg;

    // Field and dimension widths
    localparam int SRC_W  = 17;
    localparam int ERR_W  = 18;
    localparam int VIEW_W = 14;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_W = 17;
    localparam int RECIP_W = 26;

    localparam logic [SRC_W-1:0]  MAX_SOURCE_DIM = 17'd65536;
    localparam logic [VIEW_W-1:0] MAX_VIEW_DIM   = 14'd8192;
    localparam logic [SRC_W-1:0]  SRC_ROW_MAX    = 17'h1FFFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_SIZE     = 2'd2;

    // Ramp stop positions scaled to 4*h units (stop fraction * 1020)
    localparam logic [9:0] STOP_LEVEL [7] = '{
        10'd0, 10'd153, 10'd357, 10'd561, 10'd765, 10'd918, 10'd1020
    };

    // ceil(2^32 / segment length); exact floor quotient for numerators below 2^24
    localparam logic [RECIP_W-1:0] SEG_RECIP [6] = '{
        RECIP_W'((64'd4294967296 + 64'd152) / 64'd153),
        RECIP_W'((64'd4294967296 + 64'd203) / 64'd204),
        RECIP_W'((64'd4294967296 + 64'd203) / 64'd204),
        RECIP_W'((64'd4294967296 + 64'd203) / 64'd204),
        RECIP_W'((64'd4294967296 + 64'd152) / 64'd153),
        RECIP_W'((64'd4294967296 + 64'd101) / 64'd102)
    };

    // Stop colors: blue, green, yellow, orange, red, purple, white (R, G, B)
    localparam logic [7:0] STOP_RGB [7][3] = '{
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd128, 8'd0},
        '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd165, 8'd0},
        '{8'd255, 8'd0,   8'd0},
        '{8'd128, 8'd0,   8'd128},
        '{8'd255, 8'd255, 8'd255}
    };

    typedef struct packed {
        logic [7:0] height_sample;
        logic       frame_start;
    } hdc_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_row;
        logic       end_of_frame;
    } hdc_out_t;

    typedef struct packed {
        logic accept;
        logic load_frac;
        logic load_out;
    } hdc_cmd_t;

    typedef struct packed {
        logic keep;
        logic out_free;
    } hdc_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAC,
        ST_MIX
    } hdc_state_t;

endpackage

// File: hw/rtl/hdc_ctrl.sv
// Controller state machine: sample transfer, fraction step and color mix step.
module hdc_ctrl
    import hdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  hdc_status_t status,
    output hdc_cmd_t    cmd
);

    hdc_state_t state_reg;
    hdc_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one kept sample through the datapath
    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.load_frac = 1'b0;
        cmd.load_out  = 1'b0;
        sample_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.keep)
                    begin
                        state_next = ST_FRAC;
                    end
                end
            end
            ST_FRAC:
            begin
                cmd.load_frac = 1'b1;
                state_next    = ST_MIX;
            end
            ST_MIX:
            begin
                // Wait until the output register can take the pixel
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/hdc_datapath.sv
// Datapath: configuration, decimation counters, ramp fraction and color mix.
module hdc_datapath
    import hdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  hdc_in_t                sample,
    input  hdc_cmd_t               cmd,
    output hdc_status_t            status,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output hdc_out_t               pixel
);

    logic [SRC_W-1:0]  source_width_reg;
    logic [SRC_W-1:0]  source_height_reg;
    logic [VIEW_W-1:0] view_size_reg;

    logic [SRC_W-1:0]  src_col_reg, src_col_next;
    logic [SRC_W-1:0]  src_row_reg, src_row_next;
    logic [ERR_W-1:0]  col_err_reg, col_err_next;
    logic [ERR_W-1:0]  row_err_reg, row_err_next;
    logic [VIEW_W-1:0] view_col_reg, view_col_next;
    logic [VIEW_W-1:0] view_row_reg, view_row_next;
    logic              row_sel_reg, row_sel_next;

    logic [SRC_W-1:0]  w_eff, h_eff, v_clamp;
    logic [VIEW_W-1:0] v_eff;
    logic [ERR_W-1:0]  v_ext;

    logic [SRC_W-1:0]  src_col_c, src_row_c;
    logic [ERR_W-1:0]  col_err_c, row_err_c;
    logic [VIEW_W-1:0] view_col_c, view_row_c;
    logic              row_sel_c;
    logic              done, col_sel, keep, eor, eof;

    logic [2:0]        seg;
    logic [7:0]        num;
    logic [2:0]        seg_reg;
    logic [7:0]        num_reg;
    logic              eor_reg, eof_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [RECIP_W+7:0] frac_prod;
    logic [7:0]        chan [3];

    logic              pixel_valid_reg;
    hdc_out_t          pixel_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= MAX_SOURCE_DIM;
            source_height_reg <= MAX_SOURCE_DIM;
            view_size_reg     <= MAX_VIEW_DIM;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_VIEW_SIZE:     view_size_reg     <= cfg_data[VIEW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp dimensions; the view never exceeds either source size
    always_comb
    begin
        w_eff = (source_width_reg == '0) ? SRC_W'(1) :
                (source_width_reg > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : source_width_reg;
        h_eff = (source_height_reg == '0) ? SRC_W'(1) :
                (source_height_reg > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : source_height_reg;
        v_clamp = (view_size_reg == '0) ? SRC_W'(1) :
                  (view_size_reg > MAX_VIEW_DIM) ? SRC_W'(MAX_VIEW_DIM) :
                  SRC_W'(view_size_reg);
        if (v_clamp > w_eff)
        begin
            v_clamp = w_eff;
        end
        if (v_clamp > h_eff)
        begin
            v_clamp = h_eff;
        end
        v_eff = v_clamp[VIEW_W-1:0];
        v_ext = ERR_W'(v_eff);
    end

    // Select kept samples and advance the error accumulators
    always_comb
    begin
        src_col_c  = sample.frame_start ? '0 : src_col_reg;
        src_row_c  = sample.frame_start ? '0 : src_row_reg;
        col_err_c  = sample.frame_start ? '0 : col_err_reg;
        row_err_c  = sample.frame_start ? '0 : row_err_reg;
        view_col_c = sample.frame_start ? '0 : view_col_reg;
        view_row_c = sample.frame_start ? '0 : view_row_reg;
        row_sel_c  = sample.frame_start ? 1'b1 : row_sel_reg;

        done    = view_row_c >= v_eff;
        col_sel = !done && (col_err_c < v_ext) && (view_col_c < v_eff);
        keep    = col_sel && row_sel_c;
        eor     = view_col_c == (v_eff - VIEW_W'(1));
        eof     = eor && (view_row_c == (v_eff - VIEW_W'(1)));

        view_col_next = col_sel ? view_col_c + VIEW_W'(1) : view_col_c;
        col_err_next  = done ? col_err_c :
                        col_err_c + (col_sel ? ERR_W'(w_eff) : '0) - v_ext;
        src_row_next  = src_row_c;
        view_row_next = view_row_c;
        row_err_next  = row_err_c;
        row_sel_next  = row_sel_c;

        if ((ERR_W'(src_col_c) + ERR_W'(1)) >= ERR_W'(w_eff))
        begin
            // Wrap to the next source row
            src_col_next  = '0;
            col_err_next  = '0;
            view_col_next = '0;
            if (src_row_c != SRC_ROW_MAX)
            begin
                src_row_next = src_row_c + SRC_W'(1);
            end
            if (!done)
            begin
                view_row_next = row_sel_c ? view_row_c + VIEW_W'(1) : view_row_c;
                row_err_next  = row_err_c + (row_sel_c ? ERR_W'(h_eff) : '0) - v_ext;
                row_sel_next  = (row_err_next < v_ext) && (view_row_next < v_eff);
            end
        end
        else
        begin
            src_col_next = src_col_c + SRC_W'(1);
        end
    end

    // Find the ramp segment and the offset into it
    always_comb
    begin
        seg = 3'd0;
        for (int j = 1; j < 6; j++)
        begin
            if ({sample.height_sample, 2'b00} > STOP_LEVEL[j])
            begin
                seg = 3'(j);
            end
        end
        num = 8'({sample.height_sample, 2'b00} - STOP_LEVEL[seg]);
    end

    // Advance the counters on each sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            col_err_reg  <= '0;
            row_err_reg  <= '0;
            view_col_reg <= '0;
            view_row_reg <= '0;
            row_sel_reg  <= 1'b1;
        end
        else if (cmd.accept)
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            col_err_reg  <= col_err_next;
            row_err_reg  <= row_err_next;
            view_col_reg <= view_col_next;
            view_row_reg <= view_row_next;
            row_sel_reg  <= row_sel_next;
        end
    end

    // Capture segment, offset and marks of the sample
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            seg_reg <= seg;
            num_reg <= num;
            eor_reg <= eor;
            eof_reg <= eof;
        end
    end

    // Ramp fraction: offset times the reciprocal of the segment length
    assign frac_prod = {{RECIP_W{1'b0}}, num_reg} * {8'b0, SEG_RECIP[seg_reg]};

    always_ff @(posedge clk)
    begin
        if (cmd.load_frac)
        begin
            frac_reg <= frac_prod[FRAC_W+15:16];
        end
    end

    // Blend the two stop colors of the segment for each of the three channels
    always_comb
    begin
        logic [7:0]  c0, c1, dmag;
        logic [24:0] prod, base, mix;
        for (int k = 0; k < 3; k++)
        begin
            c0   = STOP_RGB[seg_reg][k];
            c1   = STOP_RGB[3'(seg_reg + 3'd1)][k];
            dmag = (c1 >= c0) ? c1 - c0 : c0 - c1;
            prod = {8'b0, frac_reg} * {17'b0, dmag};
            base = {1'b0, c0, 16'b0};
            mix  = (c1 >= c0) ? base + prod : base - prod;
            chan[k] = mix[23:16];
        end
    end

    // Output register: load a pixel, drop it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            pixel_valid_reg <= 1'b1;
        end
        else if (!pixel_stall)
        begin
            pixel_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixel_reg.red          <= chan[0];
            pixel_reg.green        <= chan[1];
            pixel_reg.blue         <= chan[2];
            pixel_reg.end_of_row   <= eor_reg;
            pixel_reg.end_of_frame <= eof_reg;
        end
    end

    assign status.keep     = keep;
    assign status.out_free = !pixel_valid_reg || !pixel_stall;
    assign pixel_valid     = pixel_valid_reg;
    assign pixel           = pixel_reg;

endmodule

// File: hw/rtl/heightmap_decimate_colormap.sv
// Top level of the heightmap decimator with color ramp output.
// Takes 8-bit height samples in raster order, keeps the nearest source pixel for each
// point of a VxV view and colors it with a seven-stop ramp (blue, green, yellow, orange,
// red, purple, white). A dropped sample does not hold off the next sample. A kept sample
// holds off the next sample transfer through the transfer itself, the ramp
// fraction multiply by a segment reciprocal, and the per-channel color blend into the
// output register; the blend step waits while a previous pixel is still stalled.
// Configuration writes are taken every cycle and act at once; write them between frames.
module heightmap_decimate_colormap
    import hdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  hdc_in_t                sample,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output hdc_out_t               pixel
);

    hdc_cmd_t    cmd;
    hdc_status_t status;

    assign cfg_ready = 1'b1;

    hdc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    hdc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .cmd         (cmd),
        .status      (status),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

// File: hw/rtl/hdc_checker.sv
// Port-level checker for the heightmap decimator, bound to the top level.
module hdc_checker
    import hdc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     sample_stall,
    input logic     pixel_valid,
    input logic     pixel_stall,
    input hdc_out_t pixel
);

    // Hold a stalled pixel
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel changed or dropped");

    // End of frame is always also end of row
    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (!pixel.end_of_frame || pixel.end_of_row))
        else $error("end_of_frame without end_of_row");

    // A new pixel appears only after the blend step, which holds off samples
    a_pixel_after_blend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid) |-> $past(sample_stall))
        else $error("pixel appeared without a blend step");

endmodule

bind heightmap_decimate_colormap hdc_checker u_hdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel)
);
